FILE: design/sha1_bsh_pkg.sv
package sha1_bsh_pkg;

    localparam int BlockWords = 16;
    localparam int ChainWords = 5;

    typedef logic [31:0] word_t;
    typedef word_t [ChainWords-1:0] chain_t;
    typedef word_t [BlockWords-1:0] block_t;

    localparam chain_t ChainInit = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    localparam logic [6:0] LastRound  = 7'd79;
    localparam logic [6:0] Phase1Start = 7'd20;
    localparam logic [6:0] Phase2Start = 7'd40;
    localparam logic [6:0] Phase3Start = 7'd60;
    localparam logic [6:0] ExpandStart = 7'd16;

    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [5:0] LastBytePos = 6'd63;
    localparam logic [5:0] LengthPos   = 6'd56;
    localparam logic [2:0] LastIndex   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } rnd_ctl_t;

endpackage

FILE: design/sha1_bsh_if.sv
interface sha1_bsh_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface sha1_bsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

FILE: design/sha1_bsh_round.sv
module sha1_bsh_round
    import sha1_bsh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rnd_ctl_t ctl,
    input  block_t   block,
    input  chain_t   chain,
    output chain_t   vars,
    output logic     done
);

    word_t      sched_reg [BlockWords];
    chain_t     vars_reg;
    chain_t     vars_next;
    logic [6:0] rnd_reg;
    logic [6:0] rnd_next;
    word_t      w;
    word_t      f;
    word_t      k;
    word_t      x;
    word_t      t;

    always_comb
    begin
        // The schedule is a shift line: tap 0 holds W[t-16], tap 13 holds W[t-3].
        x = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        if (rnd_reg < ExpandStart)
        begin
            w = sched_reg[0];
        end
        else
        begin
            w = {x[30:0], x[31]};
        end

        if (rnd_reg < Phase1Start)
        begin
            f = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            k = K0;
        end
        else if (rnd_reg < Phase2Start)
        begin
            f = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k = K1;
        end
        else if (rnd_reg < Phase3Start)
        begin
            f = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
              | (vars_reg[2] & vars_reg[3]);
            k = K2;
        end
        else
        begin
            f = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k = K3;
        end

        t = {vars_reg[0][26:0], vars_reg[0][31:27]} + f + vars_reg[4] + k + w;

        vars_next[0] = t;
        vars_next[1] = vars_reg[0];
        vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
        vars_next[3] = vars_reg[2];
        vars_next[4] = vars_reg[3];
    end

    assign done = ctl.step && (rnd_reg == LastRound);

    always_comb
    begin
        rnd_next = rnd_reg;
        if (ctl.load || done)
        begin
            rnd_next = '0;
        end
        else if (ctl.step)
        begin
            rnd_next = rnd_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
        end
        else
        begin
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            vars_reg <= chain;
            for (int i = 0; i < BlockWords; i++)
            begin
                sched_reg[i] <= block[i];
            end
        end
        else if (ctl.step)
        begin
            vars_reg <= vars_next;
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BlockWords-1] <= w;
        end
    end

    assign vars = vars_reg;

endmodule

FILE: design/sha1_byte_stream_hasher_core.sv
// SHA-1 hasher that takes a message one byte per request on the msg channel.
// A request with mode 0 appends data_byte; a request with mode 1 finishes
// the message, and the digest then leaves on the digest channel as five
// requests, word_index 0 to 4, with last_word set on the fifth.
// The 64th byte of a block starts a compression: a load step, 80 rounds on
// the shared round unit at one round per cycle, and an add step that folds
// the result into the chaining words, all with msg.ready low. A finish runs
// one compression, or two with the ST_PAD2 state between them when 56 or more
// bytes of the block are pending, before the first digest word is offered.
// The digest words are held while the receiver stalls; msg.ready stays low
// until the fifth word has been taken. After that the chaining words and the
// byte count return to their initial values and a new message begins.
// Reset puts the block in the same initial state, ready for a first byte.
module sha1_byte_stream_hasher_core
    import sha1_bsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sha1_bsh_in_if.sink           msg,
    sha1_bsh_out_if.source        digest
);

    state_t      state_reg;
    state_t      state_next;
    chain_t      chain_reg;
    chain_t      chain_next;
    logic [60:0] count_reg;
    logic [60:0] count_next;
    logic        fin_reg;
    logic        fin_next;
    logic        two_reg;
    logic        two_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    block_t      block_reg;

    rnd_ctl_t    rnd_ctl;
    chain_t      vars;
    logic        rnd_done;

    logic        in_acc;
    logic        out_acc;
    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [4:0]  shamt;
    logic [7:0]  put_byte;
    logic [63:0] bits;

    assign in_acc   = msg.valid && msg.ready;
    assign out_acc  = digest.valid && digest.ready;
    assign pos      = count_reg[5:0];
    assign widx     = count_reg[5:2];
    assign shamt    = {~count_reg[1:0], 3'b000};
    assign put_byte = msg.mode ? PadByte : msg.data_byte;
    assign bits     = {count_reg, 3'b000};

    sha1_bsh_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rnd_ctl),
        .block (block_reg),
        .chain (chain_reg),
        .vars  (vars),
        .done  (rnd_done)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (msg.mode || pos == LastBytePos))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (two_reg)
                begin
                    state_next = ST_PAD2;
                end
                else if (fin_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD2:
            begin
                state_next = ST_LOAD;
            end
            ST_EMIT:
            begin
                if (out_acc && idx_reg == LastIndex)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and control register updates.
    always_comb
    begin
        msg.ready    = 1'b0;
        digest.valid = 1'b0;
        rnd_ctl      = '0;
        chain_next   = chain_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        two_next     = two_reg;
        idx_next     = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (in_acc)
                begin
                    if (msg.mode)
                    begin
                        fin_next = 1'b1;
                        two_next = (pos >= LengthPos);
                    end
                    else
                    begin
                        count_next = count_reg + 61'd1;
                    end
                end
            end
            ST_LOAD:
            begin
                rnd_ctl.load = 1'b1;
            end
            ST_ROUND:
            begin
                rnd_ctl.step = 1'b1;
            end
            ST_ADD:
            begin
                for (int i = 0; i < ChainWords; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                two_next = 1'b0;
            end
            ST_PAD2:
            begin
            end
            ST_EMIT:
            begin
                digest.valid = 1'b1;
                if (out_acc)
                begin
                    if (idx_reg == LastIndex)
                    begin
                        idx_next   = '0;
                        fin_next   = 1'b0;
                        chain_next = ChainInit;
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LastIndex);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= ChainInit;
            count_reg <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            count_reg <= count_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            idx_reg   <= idx_next;
        end
    end

    // Block buffer: bytes pack big-endian; a finish writes the pad byte, clears
    // the rest of the block and, when it fits, the bit length; ST_PAD2 then loads a zero block with the bit length.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            for (int i = 0; i < BlockWords; i++)
            begin
                if (i == int'(widx))
                begin
                    block_reg[i] <= ((count_reg[1:0] == 2'b00) ? 32'h0 : block_reg[i])
                                  | ({24'h0, put_byte} << shamt);
                end
                else if (msg.mode && i > int'(widx))
                begin
                    if (pos < LengthPos && i == BlockWords - 2)
                    begin
                        block_reg[i] <= bits[63:32];
                    end
                    else if (pos < LengthPos && i == BlockWords - 1)
                    begin
                        block_reg[i] <= bits[31:0];
                    end
                    else
                    begin
                        block_reg[i] <= '0;
                    end
                end
            end
        end
        else if (state_reg == ST_PAD2)
        begin
            for (int i = 0; i < BlockWords - 2; i++)
            begin
                block_reg[i] <= '0;
            end
            block_reg[BlockWords-2] <= bits[63:32];
            block_reg[BlockWords-1] <= bits[31:0];
        end
    end

endmodule

FILE: bench/tb_sha1_byte_stream_hasher_core.sv
`timescale 1ns / 100ps

module tb_sha1_byte_stream_hasher_core;
    import sha1_bsh_pkg::*;

    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam int unsigned RandomItems  = 450;
    localparam int unsigned HoldCycles   = 400;
    localparam int unsigned TailCycles   = 200;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_beat_t;

    logic clk;
    logic rst_n;

    sha1_bsh_in_if  msg_if ();
    sha1_bsh_out_if digest_if ();

    sha1_byte_stream_hasher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    // Predicted hasher state.
    chain_t      msg_chain;
    block_t      msg_block;
    logic [60:0] msg_byte_count;

    digest_beat_t digest_words_due[$];

    int unsigned fail_count = 0;
    bit          src_idle_en = 1'b1;
    bit          rcv_idle_en = 1'b1;
    bit          digest_hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic chain_t sha1_compress(input chain_t h, input block_t blk);
        word_t sched [16];
        word_t a, b, c, d, e, f, k, t, x;
        int    r;
        int    s;
        for (r = 0; r < 16; r++)
        begin
            sched[r] = blk[r];
        end
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        e = h[4];
        for (r = 0; r < 80; r++)
        begin
            s = r & 15;
            if (r >= 16)
            begin
                x = sched[(s + 13) & 15] ^ sched[(s + 8) & 15] ^ sched[(s + 2) & 15]
                  ^ sched[s];
                sched[s] = {x[30:0], x[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[s];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        h[0] = h[0] + a;
        h[1] = h[1] + b;
        h[2] = h[2] + c;
        h[3] = h[3] + d;
        h[4] = h[4] + e;
        return h;
    endfunction

    task automatic sha1_take_byte(input logic [7:0] data_val);
        logic [5:0]  pos;
        int unsigned shift;
        pos = msg_byte_count[5:0];
        shift = 8 * (3 - int'(pos[1:0]));
        if (pos[1:0] == 2'd0)
        begin
            msg_block[pos[5:2]] = '0;
        end
        msg_block[pos[5:2]] |= word_t'(data_val) << shift;
        msg_byte_count = msg_byte_count + 61'd1;
        if (pos == LastBytePos)
        begin
            msg_chain = sha1_compress(msg_chain, msg_block);
        end
    endtask

    task automatic sha1_finish_message();
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        int unsigned  shift;
        int           i;
        digest_beat_t beat;
        pos = msg_byte_count[5:0];
        bit_len = {msg_byte_count, 3'b000};
        shift = 8 * (3 - int'(pos[1:0]));
        if (pos[1:0] == 2'd0)
        begin
            msg_block[pos[5:2]] = '0;
        end
        msg_block[pos[5:2]] |= word_t'(PadByte) << shift;
        for (i = int'(pos[5:2]) + 1; i < BlockWords; i++)
        begin
            msg_block[i] = '0;
        end
        // With no room left for the length, the pad byte closes one block
        // and the length goes into an extra all-zero block.
        if (pos >= LengthPos)
        begin
            msg_chain = sha1_compress(msg_chain, msg_block);
            msg_block = '0;
        end
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        msg_chain = sha1_compress(msg_chain, msg_block);
        for (i = 0; i < ChainWords; i++)
        begin
            beat.word  = msg_chain[i];
            beat.index = 3'(i);
            beat.last  = (3'(i) == LastIndex);
            digest_words_due.push_back(beat);
        end
        msg_chain = ChainInit;
        msg_byte_count = '0;
    endtask

    task automatic send_request(input logic req_mode, input logic [7:0] req_byte);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid     <= 1'b1;
        msg_if.mode      <= req_mode;
        msg_if.data_byte <= req_byte;
        do @(posedge clk); while (!msg_if.ready);
        if (req_mode == MODE_DATA)
        begin
            sha1_take_byte(req_byte);
        end
        else
        begin
            sha1_finish_message();
        end
    endtask

    task automatic send_message(input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            send_request(MODE_DATA, 8'($urandom_range(0, 255)));
        end
        send_request(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_digests();
        msg_if.valid <= 1'b0;
        while (digest_words_due.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_digest_word();
        digest_beat_t due;
        if (digest_words_due.size() == 0)
        begin
            $error("digest_word %h arrived with no digest pending", digest_if.digest_word);
            fail_count++;
        end
        else
        begin
            due = digest_words_due.pop_front();
            if (digest_if.digest_word !== due.word)
            begin
                $error("digest_word: expected %h, got %h", due.word, digest_if.digest_word);
                fail_count++;
            end
            if (digest_if.word_index !== due.index)
            begin
                $error("word_index: expected %0d, got %0d", due.index, digest_if.word_index);
                fail_count++;
            end
            if (digest_if.last_word !== due.last)
            begin
                $error("last_word: expected %0d, got %0d", due.last, digest_if.last_word);
                fail_count++;
            end
        end
    endtask

    task automatic test_empty_message();
        // Two finishes in a row: both give the digest of the empty string.
        send_request(MODE_FINISH, 8'h00);
        send_request(MODE_FINISH, 8'hff);
        wait_for_digests();
    endtask

    task automatic test_short_message();
        send_request(MODE_DATA, 8'h61);
        send_request(MODE_DATA, 8'h62);
        send_request(MODE_DATA, 8'h63);
        send_request(MODE_FINISH, 8'h00);
        wait_for_digests();
    endtask

    task automatic test_byte_extremes();
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'hff);
        send_request(MODE_DATA, 8'h80);
        send_request(MODE_DATA, 8'h7f);
        send_request(MODE_DATA, 8'h01);
        send_request(MODE_FINISH, 8'h55);
        wait_for_digests();
    endtask

    task automatic test_digest_backpressure();
        int unsigned i;
        // The receiver stalls after the first digest word while the sender
        // keeps offering bytes, so the input side has to back up.
        src_idle_en = 1'b0;
        digest_hold_req = 1'b1;
        send_message(5);
        for (i = 0; i < 8; i++)
        begin
            send_request(MODE_DATA, 8'($urandom_range(0, 255)));
        end
        send_request(MODE_FINISH, 8'($urandom_range(0, 255)));
        wait_for_digests();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        int unsigned n;
        int unsigned boundary_len [4];
        boundary_len[0] = 55;
        boundary_len[1] = 56;
        boundary_len[2] = 63;
        boundary_len[3] = 64;
        sent = 0;
        n = 0;
        while (sent < RandomItems)
        begin
            if (n < 4)
            begin
                len = boundary_len[n];
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: len = $urandom_range(0, 20);
                    4, 5, 6:    len = $urandom_range(52, 68);
                    7:          len = $urandom_range(110, 135);
                    8:          len = 0;
                    default:    len = $urandom_range(0, 70);
                endcase
            end
            src_idle_en = ($urandom_range(0, 3) != 0);
            rcv_idle_en = ($urandom_range(0, 3) != 0);
            send_message(len);
            sent += len + 1;
            n++;
        end
        wait_for_digests();
        src_idle_en = 1'b1;
        rcv_idle_en = 1'b1;
    endtask

    initial
    begin
        int unsigned stall;
        digest_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (digest_hold_req)
            begin
                stall = HoldCycles;
                digest_hold_req = 1'b0;
            end
            else
            begin
                stall = rcv_idle_en ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0)
            begin
                digest_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digest_if.ready <= 1'b1;
            do @(posedge clk); while (!digest_if.valid);
            check_digest_word();
        end
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        msg_if.valid     <= 1'b0;
        msg_if.mode      <= MODE_DATA;
        msg_if.data_byte <= 8'h00;
        msg_chain = ChainInit;
        msg_block = '0;
        msg_byte_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_short_message();
        test_byte_extremes();
        test_digest_backpressure();
        test_random_messages();

        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sha1_bsh_pkg.sv
design/sha1_bsh_if.sv
design/sha1_bsh_round.sv
design/sha1_byte_stream_hasher_core.sv
bench/tb_sha1_byte_stream_hasher_core.sv
